### hdl/vbsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel block stream checker package
// Shared widths, codes and bundle types of the voxel block stream checker.
// ----------------------------------------------------------------------------
package vbsc_pkg;

  localparam int unsigned LOC_BITS_DEF  = 24;
  localparam int unsigned GRID_W        = 16;
  localparam int unsigned PROD_W        = 3 * GRID_W;
  localparam int unsigned COUNT_W       = 31;
  localparam int unsigned START_W       = 32;
  localparam int unsigned MASK_W        = 64;
  localparam int unsigned COARSE_W      = 8;
  localparam int unsigned POP_W         = 7;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned SETTLE_W      = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_BAD_GRID   = 3'd1,
    STATUS_BAD_LOC    = 3'd2,
    STATUS_BAD_START  = 3'd3,
    STATUS_BAD_COARSE = 3'd4,
    STATUS_BAD_COUNT  = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X     = 3'd0,
    CFG_GRID_Y     = 3'd1,
    CFG_GRID_Z     = 3'd2,
    CFG_OCCUPIED   = 3'd3,
    CFG_VOXEL_DATA = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [START_W-1:0] render_start;
    logic               last_block;
    logic [POP_W-1:0]   pop;
    logic               coarse_ok;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] occupied_count;
    logic [COUNT_W-1:0] voxel_data_count;
    logic               grid_ok;
    logic               settling;
  } cfg_t;

endpackage

### hdl/vbsc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel block stream checker channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vbsc_req_if #(
  parameter int unsigned LocBits = vbsc_pkg::LOC_BITS_DEF
);
  import vbsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [COARSE_W-1:0] coarse_bits;
  logic [LocBits-1:0]  block_location;
  logic [MASK_W-1:0]   occupancy_mask;
  logic [START_W-1:0]  render_start;
  logic                last_block;

  modport source (output valid, coarse_bits, block_location, occupancy_mask,
                  render_start, last_block, input ready);
  modport sink   (input valid, coarse_bits, block_location, occupancy_mask,
                  render_start, last_block, output ready);
endinterface

interface vbsc_rsp_if;
  import vbsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               run_end;
  logic [COUNT_W-1:0] voxel_total;

  modport source (output valid, status, run_end, voxel_total, input ready);
  modport sink   (input valid, status, run_end, voxel_total, output ready);
endinterface

interface vbsc_cfg_if;
  import vbsc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/vbsc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel block stream checker configuration
// Holds the configuration registers and derives the grid block count in a
// short multiplier pipeline.
// ----------------------------------------------------------------------------
module vbsc_cfg_regs #(
  parameter int unsigned LocBits = vbsc_pkg::LOC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [vbsc_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [vbsc_pkg::CFG_DATA_W-1:0] data_i,
  output vbsc_pkg::cfg_t                  cfg_o,
  output logic [LocBits-1:0]              blocks_o
);
  import vbsc_pkg::*;

  logic [GRID_W-1:0]   gx_q, gy_q, gz_q;
  logic [COUNT_W-1:0]  occ_q, vdc_q;
  logic [2*GRID_W-1:0] xy_q, xy_d;
  logic [PROD_W-1:0]   xyz_q, xyz_d;
  logic                grid_ok_q, grid_ok_d;
  logic [LocBits-1:0]  blocks_q;
  logic [SETTLE_W-1:0] settle_q, settle_d;

  assign xy_d      = (2*GRID_W)'(gx_q) * (2*GRID_W)'(gy_q);
  assign xyz_d     = PROD_W'(xy_q) * PROD_W'(gz_q);
  assign grid_ok_d = (xyz_q != '0) && (xyz_q[PROD_W-1:LocBits] == '0);

  always_comb begin
    settle_d = settle_q;
    if (we_i) begin
      settle_d = SETTLE_CYCLES;
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q      <= '0;
      gy_q      <= '0;
      gz_q      <= '0;
      occ_q     <= '0;
      vdc_q     <= '0;
      xy_q      <= '0;
      xyz_q     <= '0;
      grid_ok_q <= 1'b0;
      blocks_q  <= '0;
      settle_q  <= '0;
    end else begin
      if (we_i) begin
        case (cfg_idx_e'(idx_i))
          CFG_GRID_X:     gx_q  <= data_i[GRID_W-1:0];
          CFG_GRID_Y:     gy_q  <= data_i[GRID_W-1:0];
          CFG_GRID_Z:     gz_q  <= data_i[GRID_W-1:0];
          CFG_OCCUPIED:   occ_q <= data_i[COUNT_W-1:0];
          CFG_VOXEL_DATA: vdc_q <= data_i[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
      xy_q      <= xy_d;
      xyz_q     <= xyz_d;
      grid_ok_q <= grid_ok_d;
      blocks_q  <= xyz_q[LocBits-1:0];
      settle_q  <= settle_d;
    end
  end

  assign cfg_o.occupied_count   = occ_q;
  assign cfg_o.voxel_data_count = vdc_q;
  assign cfg_o.grid_ok          = grid_ok_q;
  assign cfg_o.settling         = (settle_q != '0);
  assign blocks_o               = blocks_q;

endmodule

### hdl/vbsc_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel block stream checker input stage
// Registers each request together with the popcount of its fine mask and
// the result of the coarse mask comparison.
// ----------------------------------------------------------------------------
module vbsc_prep #(
  parameter int unsigned LocBits = vbsc_pkg::LOC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic                            advance_i,
  input  logic [vbsc_pkg::COARSE_W-1:0]   coarse_i,
  input  logic [LocBits-1:0]              loc_i,
  input  logic [vbsc_pkg::MASK_W-1:0]     mask_i,
  input  logic [vbsc_pkg::START_W-1:0]    start_i,
  input  logic                            last_i,
  output logic                            valid_o,
  output vbsc_pkg::item_t                 item_o,
  output logic [LocBits-1:0]              loc_o
);
  import vbsc_pkg::*;

  function automatic logic [POP_W-1:0] ones64(input logic [MASK_W-1:0] v);
    logic [1:0] s1 [32];
    logic [2:0] s2 [16];
    logic [3:0] s3 [8];
    logic [4:0] s4 [4];
    logic [5:0] s5 [2];
    for (int i = 0; i < 32; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    return {1'b0, s5[0]} + {1'b0, s5[1]};
  endfunction

  // Coarse bit cx+2cy+4cz is the OR of fine bits x+4y+16z in its 2x2x2 group.
  function automatic logic [COARSE_W-1:0] coarse_of(input logic [MASK_W-1:0] v);
    logic [COARSE_W-1:0] res;
    logic [5:0]          bit_idx;
    res = '0;
    for (int c = 0; c < 8; c++) begin
      for (int d = 0; d < 8; d++) begin
        bit_idx = 6'((2 * (c & 1) + (d & 1))
                     + 4 * (2 * ((c >> 1) & 1) + ((d >> 1) & 1))
                     + 16 * (2 * ((c >> 2) & 1) + ((d >> 2) & 1)));
        res[c] = res[c] | v[bit_idx];
      end
    end
    return res;
  endfunction

  logic         valid_q, valid_d;
  item_t        item_q;
  logic [LocBits-1:0] loc_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q.render_start <= start_i;
      item_q.last_block   <= last_i;
      item_q.pop          <= ones64(mask_i);
      item_q.coarse_ok    <= (coarse_of(mask_i) == coarse_i);
      loc_q               <= loc_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign loc_o   = loc_q;

endmodule

### hdl/vbsc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel block stream checker core
// Applies the ordered record checks against the running state and holds
// the response register.
// ----------------------------------------------------------------------------
module vbsc_check #(
  parameter int unsigned LocBits = vbsc_pkg::LOC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  vbsc_pkg::item_t    item_i,
  input  logic [LocBits-1:0] loc_i,
  input  vbsc_pkg::cfg_t     cfg_i,
  input  logic [LocBits-1:0] blocks_i,
  output logic               advance_o,
  output logic               busy_o,
  vbsc_rsp_if.source         rsp_o
);
  import vbsc_pkg::*;

  logic [LocBits-1:0] prev_q, prev_d, prev_new;
  logic               seen_q, seen_d, seen_new;
  logic [COUNT_W-1:0] run_q, run_d, run_new, run_add;
  status_e            err_q, err_d, err_new;
  logic [COUNT_W:0]   sum;
  logic               take;

  logic               out_valid_q, out_valid_d;
  status_e            status_q;
  logic               run_end_q;
  logic [COUNT_W-1:0] total_q;

  assign advance_o = !out_valid_q || rsp_o.ready;
  assign take      = advance_o && item_valid_i;
  assign busy_o    = item_valid_i || out_valid_q;

  assign sum     = {1'b0, run_q} + (COUNT_W+1)'(item_i.pop);
  assign run_add = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

  always_comb begin
    err_new  = err_q;
    prev_new = prev_q;
    seen_new = seen_q;
    run_new  = run_q;
    if (err_q == STATUS_OK) begin
      if (!cfg_i.grid_ok) begin
        err_new = STATUS_BAD_GRID;
      end else if ((seen_q && (loc_i <= prev_q)) || (loc_i >= blocks_i)) begin
        err_new = STATUS_BAD_LOC;
      end else if (item_i.render_start != {1'b0, run_q}) begin
        err_new = STATUS_BAD_START;
      end else if (!item_i.coarse_ok) begin
        err_new = STATUS_BAD_COARSE;
      end else begin
        prev_new = loc_i;
        seen_new = 1'b1;
        run_new  = run_add;
      end
    end
    if (item_i.last_block && (err_new == STATUS_OK) &&
        ((run_new != cfg_i.occupied_count) || (run_new != cfg_i.voxel_data_count))) begin
      err_new = STATUS_BAD_COUNT;
    end
  end

  always_comb begin
    err_d  = err_q;
    prev_d = prev_q;
    seen_d = seen_q;
    run_d  = run_q;
    if (take) begin
      if (item_i.last_block) begin
        err_d  = STATUS_OK;
        prev_d = '0;
        seen_d = 1'b0;
        run_d  = '0;
      end else begin
        err_d  = err_new;
        prev_d = prev_new;
        seen_d = seen_new;
        run_d  = run_new;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = item_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q       <= STATUS_OK;
      prev_q      <= '0;
      seen_q      <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      err_q       <= err_d;
      prev_q      <= prev_d;
      seen_q      <= seen_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q  <= err_new;
      run_end_q <= item_i.last_block;
      total_q   <= run_new;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.run_end     = run_end_q;
  assign rsp_o.voxel_total = total_q;

  // A set that has not yet passed a record has counted no voxels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (run_q == '0))
    else $error("Voxel count is nonzero before any block passed.");

  // Once an error is recorded, the next response repeats it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (err_q != STATUS_OK)) |=> (status_q == $past(err_q)))
    else $error("Recorded error code did not stick.");

  // The final record of a set leaves the state cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.last_block) |=>
      ((err_q == STATUS_OK) && !seen_q && (run_q == '0) && (prev_q == '0)))
    else $error("State not cleared after the final record.");

endmodule

### hdl/voxel_block_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel block stream checker
// Checks a stream of sparse voxel block records and reports a sticky status.
// ----------------------------------------------------------------------------
// A request passes the input register and then the response register.
// Throughput is one request per cycle while responses are not stalled and no
// configuration write is pending or settling. A configuration write holds off
// requests while the grid block count passes through its two multiplier stages.
// Reset is asynchronous and clears configuration, check state and valid flags.
module voxel_block_stream_checker #(
  parameter int unsigned LocBits = vbsc_pkg::LOC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vbsc_req_if.sink   req_i,
  vbsc_rsp_if.source rsp_o,
  vbsc_cfg_if.sink   cfg_i
);
  import vbsc_pkg::*;

  cfg_t               cfg;
  logic [LocBits-1:0] blocks;
  logic               advance;
  logic               busy;
  logic               item_valid;
  item_t              item;
  logic [LocBits-1:0] item_loc;
  logic               req_take;
  logic               cfg_take;

  assign cfg_i.ready = !busy;
  assign cfg_take    = cfg_i.valid && cfg_i.ready;
  assign req_i.ready = !cfg.settling && !cfg_i.valid && (!item_valid || advance);
  assign req_take    = req_i.valid && req_i.ready;

  vbsc_cfg_regs #(
    .LocBits (LocBits)
  ) u_cfg_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (cfg_take),
    .idx_i    (cfg_i.index),
    .data_i   (cfg_i.data),
    .cfg_o    (cfg),
    .blocks_o (blocks)
  );

  vbsc_prep #(
    .LocBits (LocBits)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (req_take),
    .advance_i (advance),
    .coarse_i  (req_i.coarse_bits),
    .loc_i     (req_i.block_location),
    .mask_i    (req_i.occupancy_mask),
    .start_i   (req_i.render_start),
    .last_i    (req_i.last_block),
    .valid_o   (item_valid),
    .item_o    (item),
    .loc_o     (item_loc)
  );

  vbsc_check #(
    .LocBits (LocBits)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .loc_i        (item_loc),
    .cfg_i        (cfg),
    .blocks_i     (blocks),
    .advance_o    (advance),
    .busy_o       (busy),
    .rsp_o        (rsp_o)
  );

endmodule
